FILE: rtl/rpmt_pkg.sv
// shared types, constants and seed table of the rotating pattern memory test
package rpmt_pkg;

  localparam int DataW    = 32;
  localparam int AddrW    = 32;
  localparam int CntW     = 32;
  localparam int WordIdxW = 30;
  localparam int LenW     = 31;
  localparam int PassW    = 16;
  localparam int ErrLimW  = 16;
  localparam int BitSelW  = 5;
  localparam int NumBits  = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [LenW-1:0] MaxLen = LenW'(32'h4000_0000);

  // command codes
  localparam logic [1:0] CmdStart = 2'd0;
  localparam logic [1:0] CmdAck   = 2'd1;
  localparam logic [1:0] CmdQuery = 2'd2;

  // access kinds
  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindRead  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegBase    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLength  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPasses  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxErr  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegXorAddr = 3'd4;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhWrite = 2'd1,
    PhRead  = 2'd2,
    PhDone  = 2'd3
  } phase_e;

  typedef logic [DataW-1:0] data_t;

  // pass seed, indexed by pass number mod 8
  function automatic data_t seed_lookup(input logic [2:0] idx);
    data_t s;
    case (idx)
      3'd0:    s = 32'h0000_0000;
      3'd1:    s = 32'hffff_ffff;
      3'd2:    s = 32'h5555_5555;
      3'd3:    s = 32'h0000_0001;
      3'd4:    s = 32'hffff_fffe;
      3'd5:    s = 32'h1111_1111;
      3'd6:    s = 32'h0000_000f;
      3'd7:    s = 32'h0000_00ff;
      default: s = 32'h0000_0000;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/rpmt_intf.sv
// handshake channels: configuration writes, command beats and result beats
interface rpmt_cfg_if;
  import rpmt_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface rpmt_in_if;
  import rpmt_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [DataW-1:0]   read_data;
  logic [BitSelW-1:0] bit_select;
  modport source (output valid, output command, output read_data, output bit_select,
                  input ready);
  modport sink (input valid, input command, input read_data, input bit_select,
                output ready);
endinterface

interface rpmt_out_if;
  import rpmt_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       access_kind;
  logic [AddrW-1:0] access_address;
  logic [DataW-1:0] access_data;
  logic [CntW-1:0]  error_count;
  logic [AddrW-1:0] last_error_address;
  logic             done_res;
  logic [CntW-1:0]  bit_error_count;
  modport source (output valid, output access_kind, output access_address,
                  output access_data, output error_count, output last_error_address,
                  output done_res, output bit_error_count, input ready);
  modport sink (input valid, input access_kind, input access_address,
                input access_data, input error_count, input last_error_address,
                input done_res, input bit_error_count, output ready);
endinterface

FILE: rtl/rotating_pattern_memory_test_top.sv
// rotating pattern memory test sequencer, top level
// a result beat is registered, valid in the cycle after its command beat is accepted
// throughput: one command beat per cycle unless stalled; a new beat is taken while
//   the held result drains, the single result register is the only buffering stage
// reset: asynchronous, active low; idle phase, counters cleared, registers at defaults
// configuration writes are taken every cycle
module rotating_pattern_memory_test_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  rpmt_cfg_if.sink       cfg_i,
  rpmt_in_if.sink        in_i,
  rpmt_out_if.source     out_o
);
  import rpmt_pkg::*;

  // configuration registers
  logic [AddrW-1:0]   base_q;
  logic [LenW-1:0]    length_q;
  logic [PassW-1:0]   passes_q;
  logic [ErrLimW-1:0] max_err_q;
  logic               xor_en_q;

  // sequencer state
  phase_e              phase_q, phase_d;
  logic [PassW-1:0]    pass_q, pass_d;
  logic [WordIdxW-1:0] word_q, word_d;
  data_t               pattern_q, pattern_d;
  logic [CntW-1:0]     mis_q, mis_d;
  logic [WordIdxW-1:0] lfi_q, lfi_d;
  logic [CntW-1:0]     bit_cnt_q [NumBits];
  logic [CntW-1:0]     bit_cnt_d [NumBits];

  // result register
  logic             out_valid_q;
  logic [1:0]       kind_q, kind_d;
  logic [AddrW-1:0] addr_q, addr_d;
  data_t            data_q, data_d;
  logic [AddrW-1:0] last_addr_q, last_addr_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  bit_out_q, bit_out_d;

  logic             in_fire;
  logic [LenW-1:0]  eff_len;
  logic             last_word;
  logic [AddrW-1:0] cur_addr;
  data_t            cur_exp;
  data_t            diff;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      length_q  <= LenW'(4096);
      passes_q  <= PassW'(8);
      max_err_q <= ErrLimW'(1);
      xor_en_q  <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegBase:    base_q    <= cfg_i.data[AddrW-1:0];
        RegLength:  length_q  <= cfg_i.data[LenW-1:0];
        RegPasses:  passes_q  <= cfg_i.data[PassW-1:0];
        RegMaxErr:  max_err_q <= cfg_i.data[ErrLimW-1:0];
        RegXorAddr: xor_en_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // current access and its compare against the returned word
  assign eff_len   = (length_q > MaxLen) ? MaxLen : length_q;
  assign last_word = ({1'b0, word_q} + LenW'(1)) >= eff_len;
  assign cur_addr  = base_q + {word_q, 2'b00};
  assign cur_exp   = pattern_q ^ (xor_en_q ? cur_addr : '0);
  assign diff      = in_i.read_data ^ cur_exp;

  // next state
  always_comb begin
    phase_d   = phase_q;
    pass_d    = pass_q;
    word_d    = word_q;
    pattern_d = pattern_q;
    mis_d     = mis_q;
    lfi_d     = lfi_q;
    bit_cnt_d = bit_cnt_q;
    if (in_fire) begin
      case (in_i.command)
        CmdStart: begin
          mis_d  = '0;
          lfi_d  = '0;
          pass_d = '0;
          for (int k = 0; k < NumBits; k++) bit_cnt_d[k] = '0;
          if ((passes_q != '0) && (max_err_q != '0) && (length_q != '0)) begin
            phase_d   = PhWrite;
            word_d    = '0;
            pattern_d = seed_lookup(3'd0);
          end else begin
            phase_d = PhDone;
          end
        end
        CmdAck: begin
          if (phase_q == PhWrite || phase_q == PhRead) begin
            // read check: word count, failing word and per-bit counters
            if (phase_q == PhRead && diff != '0) begin
              if (mis_q != '1) mis_d = mis_q + CntW'(1);
              lfi_d = word_q;
              for (int k = 0; k < NumBits; k++) begin
                if (diff[k] && bit_cnt_q[k] != '1) bit_cnt_d[k] = bit_cnt_q[k] + CntW'(1);
              end
            end
            if (!last_word) begin
              word_d    = word_q + WordIdxW'(1);
              pattern_d = {pattern_q[DataW-2:0], pattern_q[DataW-1]};
            end else if (phase_q == PhWrite) begin
              phase_d   = PhRead;
              word_d    = '0;
              pattern_d = seed_lookup(pass_q[2:0]);
            end else begin
              pass_d = pass_q + PassW'(1);
              if (pass_d == '0) begin
                phase_d = PhDone;
              end else if ((pass_d < passes_q) && (mis_d < CntW'(max_err_q))
                           && (length_q != '0)) begin
                phase_d   = PhWrite;
                word_d    = '0;
                pattern_d = seed_lookup(pass_d[2:0]);
              end else begin
                phase_d = PhDone;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result beat built from the updated state
  always_comb begin
    addr_d      = base_q + {word_d, 2'b00};
    kind_d      = KindNone;
    data_d      = '0;
    done_d      = 1'b0;
    case (phase_d)
      PhWrite: kind_d = KindWrite;
      PhRead:  kind_d = KindRead;
      default: done_d = 1'b1;
    endcase
    if (done_d) begin
      addr_d = '0;
    end else begin
      data_d = pattern_d ^ (xor_en_q ? addr_d : '0);
    end
    last_addr_d = base_q + {lfi_d, 2'b00};
    bit_out_d   = bit_cnt_d[in_i.bit_select];
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      pass_q    <= '0;
      word_q    <= '0;
      pattern_q <= '0;
      mis_q     <= '0;
      lfi_q     <= '0;
      for (int k = 0; k < NumBits; k++) bit_cnt_q[k] <= '0;
    end else begin
      phase_q   <= phase_d;
      pass_q    <= pass_d;
      word_q    <= word_d;
      pattern_q <= pattern_d;
      mis_q     <= mis_d;
      lfi_q     <= lfi_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q      <= kind_d;
      addr_q      <= addr_d;
      data_q      <= data_d;
      last_addr_q <= last_addr_d;
      done_q      <= done_d;
      bit_out_q   <= bit_out_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.access_kind        = kind_q;
  assign out_o.access_address     = addr_q;
  assign out_o.access_data        = data_q;
  assign out_o.error_count        = mis_q;
  assign out_o.last_error_address = last_addr_q;
  assign out_o.done_res           = done_q;
  assign out_o.bit_error_count    = bit_out_q;

endmodule

FILE: test/tb_rotating_pattern_memory_test_top.sv
// self-checking testbench of the rotating pattern memory test sequencer
module tb_rotating_pattern_memory_test_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rpmt_pkg::*;

  // command code with no meaning, the block treats it like a query
  localparam logic [1:0] CmdSpare = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemTarget = 500;
  localparam int unsigned SessionCap = 80;

  // pass seeds, picked by pass number mod 8
  localparam data_t SeedTab [8] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h5555_5555, 32'h0000_0001,
    32'hffff_fffe, 32'h1111_1111, 32'h0000_000f, 32'h0000_00ff
  };

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    logic [CntW-1:0]  errs;
    logic [AddrW-1:0] last_addr;
    logic             done;
    logic [CntW-1:0]  bit_errs;
  } access_beat_t;

  // tracks the sequencer state and holds the result beats still owed
  class bist_tracker;
    logic [AddrW-1:0]    base_addr;
    logic [LenW-1:0]     region_len;
    logic [PassW-1:0]    pass_limit;
    logic [ErrLimW-1:0]  err_limit;
    logic                xor_addr;
    phase_e              phase;
    logic [PassW-1:0]    pass_no;
    logic [WordIdxW-1:0] word_no;
    data_t               pattern;
    logic [CntW-1:0]     word_errs;
    logic [WordIdxW-1:0] fail_word;
    logic [CntW-1:0]     bit_errs [NumBits];
    access_beat_t        awaited_beats [$];
    int unsigned         bad_fields;
    int unsigned         checked_beats;

    function new();
      base_addr = '0;
      region_len = LenW'(4096);
      pass_limit = PassW'(8);
      err_limit = ErrLimW'(1);
      xor_addr = 1'b0;
      phase = PhIdle;
      pass_no = '0;
      word_no = '0;
      pattern = '0;
      word_errs = '0;
      fail_word = '0;
      foreach (bit_errs[k]) bit_errs[k] = '0;
      bad_fields = 0;
      checked_beats = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegBase:    base_addr = val;
        RegLength:  region_len = val[LenW-1:0];
        RegPasses:  pass_limit = val[PassW-1:0];
        RegMaxErr:  err_limit = val[ErrLimW-1:0];
        RegXorAddr: xor_addr = val[0];
        default: ;
      endcase
    endfunction

    // region length with the oversize cap applied
    function logic [LenW-1:0] span();
      return (region_len > MaxLen) ? MaxLen : region_len;
    endfunction

    function logic [AddrW-1:0] byte_addr(logic [WordIdxW-1:0] idx);
      return base_addr + {idx, 2'b00};
    endfunction

    function data_t word_now();
      return xor_addr ? (pattern ^ byte_addr(word_no)) : pattern;
    endfunction

    function bit busy();
      return phase == PhWrite || phase == PhRead;
    endfunction

    function void open_pass();
      if (pass_no < pass_limit && word_errs < CntW'(err_limit) && span() != '0) begin
        phase = PhWrite;
        word_no = '0;
        pattern = SeedTab[pass_no[2:0]];
      end else begin
        phase = PhDone;
      end
    endfunction

    // advance on one accepted command beat and queue the result it owes
    function void take_command(logic [1:0] cmd, data_t rd, logic [BitSelW-1:0] sel);
      data_t        diff;
      bit           last;
      access_beat_t b;
      if (cmd == CmdStart) begin
        word_errs = '0;
        fail_word = '0;
        foreach (bit_errs[k]) bit_errs[k] = '0;
        pass_no = '0;
        open_pass();
      end else if (cmd == CmdAck && busy()) begin
        last = (32'(word_no) + 32'd1) >= 32'(span());
        // compare the word read back and count every differing bit
        if (phase == PhRead) begin
          diff = rd ^ word_now();
          if (diff != '0) begin
            if (word_errs != '1) word_errs++;
            fail_word = word_no;
            for (int k = 0; k < NumBits; k++) begin
              if (diff[k] && bit_errs[k] != '1) bit_errs[k]++;
            end
          end
        end
        if (!last) begin
          word_no++;
          pattern = {pattern[DataW-2:0], pattern[DataW-1]};
        end else if (phase == PhWrite) begin
          phase = PhRead;
          word_no = '0;
          pattern = SeedTab[pass_no[2:0]];
        end else begin
          pass_no++;
          if (pass_no == '0) phase = PhDone;
          else open_pass();
        end
      end
      b.kind = KindNone;
      b.addr = '0;
      b.data = '0;
      if (busy()) begin
        b.kind = (phase == PhWrite) ? KindWrite : KindRead;
        b.addr = byte_addr(word_no);
        b.data = word_now();
      end
      b.errs = word_errs;
      b.last_addr = byte_addr(fail_word);
      b.done = (phase == PhIdle || phase == PhDone);
      b.bit_errs = bit_errs[sel];
      awaited_beats.push_back(b);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      bad_fields++;
      if (bad_fields <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    // compare one result beat with the oldest one owed
    function void match_beat(access_beat_t got);
      access_beat_t want;
      checked_beats++;
      if (awaited_beats.size() == 0) begin
        flag("result beat with none owed", '0, got.addr);
        return;
      end
      want = awaited_beats.pop_front();
      if (got.kind !== want.kind) flag("access_kind", want.kind, got.kind);
      if (got.addr !== want.addr) flag("access_address", want.addr, got.addr);
      if (got.data !== want.data) flag("access_data", want.data, got.data);
      if (got.errs !== want.errs) flag("error_count", want.errs, got.errs);
      if (got.last_addr !== want.last_addr)
        flag("last_error_address", want.last_addr, got.last_addr);
      if (got.done !== want.done) flag("done_res", want.done, got.done);
      if (got.bit_errs !== want.bit_errs)
        flag("bit_error_count", want.bit_errs, got.bit_errs);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  bit          calm;
  int unsigned useful_beats;
  int unsigned corrupted_reads;
  int unsigned settings_used;
  int unsigned cycles;
  int          stall_left;
  bist_tracker tracker;

  rpmt_cfg_if cfg_if ();
  rpmt_in_if  in_if ();
  rpmt_out_if out_if ();

  rotating_pattern_memory_test_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  // watch all three channels at the rising edge
  always @(posedge clk_i) begin : monitor
    access_beat_t got;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) tracker.write_reg(cfg_if.index, cfg_if.data);
      if (out_if.valid && out_if.ready) begin
        got.kind = out_if.access_kind;
        got.addr = out_if.access_address;
        got.data = out_if.access_data;
        got.errs = out_if.error_count;
        got.last_addr = out_if.last_error_address;
        got.done = out_if.done_res;
        got.bit_errs = out_if.bit_error_count;
        tracker.match_beat(got);
      end
      if (in_if.valid && in_if.ready)
        tracker.take_command(in_if.command, in_if.read_data, in_if.bit_select);
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("no progress after %0d cycles", cycles);
    $display("[FAIL] regression broken");
    $finish;
  end

  // one command beat, called and returning at a falling edge
  task automatic send_beat(logic [1:0] cmd, data_t rd, logic [BitSelW-1:0] sel);
    int gap;
    gap = pick_gap();
    if (cmd == CmdStart || cmd == CmdQuery || (cmd == CmdAck && tracker.busy()))
      useful_beats++;
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.command = cmd;
    in_if.read_data = rd;
    in_if.bit_select = sel;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // complete the current access, answering reads with the right word unless corrupted
  task automatic issue_ack(bit corrupt);
    data_t rd;
    data_t mask;
    rd = (tracker.phase == PhRead) ? tracker.word_now() : data_t'($urandom());
    if (corrupt && tracker.phase == PhRead) begin
      case ($urandom_range(0, 3))
        0:       mask = data_t'(1) << $urandom_range(0, DataW - 1);
        1:       mask = data_t'($urandom()) | data_t'(1);
        2:       mask = '1;
        default: mask = (data_t'(1) << $urandom_range(0, 15)) |
                        (data_t'(1) << $urandom_range(16, 31));
      endcase
      rd ^= mask;
      corrupted_reads++;
    end
    send_beat(CmdAck, rd, BitSelW'($urandom()));
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
  endtask

  // wait until every owed result beat has come back
  task automatic drain();
    in_if.valid = 1'b0;
    while (tracker.awaited_beats.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic apply_setting(logic [AddrW-1:0] base, logic [LenW-1:0] len,
                               logic [PassW-1:0] passes, logic [ErrLimW-1:0] maxerr,
                               logic xorv);
    drain();
    write_cfg(RegBase, base);
    write_cfg(RegLength, CfgDataW'(len));
    write_cfg(RegPasses, CfgDataW'(passes));
    write_cfg(RegMaxErr, CfgDataW'(maxerr));
    write_cfg(RegXorAddr, CfgDataW'(xorv));
    cfg_if.valid = 1'b0;
    settings_used++;
  endtask

  task automatic start_test();
    send_beat(CmdStart, data_t'($urandom()), BitSelW'($urandom()));
  endtask

  // one started test driven with mostly well-formed completions
  task automatic run_session();
    int unsigned steps;
    int          r;
    start_test();
    steps = 0;
    while (tracker.busy() && steps < SessionCap) begin
      r = $urandom_range(0, 99);
      if (r < 84) issue_ack($urandom_range(0, 9) == 0);
      else if (r < 91) send_beat(CmdQuery, data_t'($urandom()), BitSelW'($urandom()));
      else if (r < 96) send_beat(CmdSpare, data_t'($urandom()), BitSelW'($urandom()));
      else start_test();
      steps++;
    end
    // read out some bit counters, then a stray completion
    repeat ($urandom_range(1, 4))
      send_beat(CmdQuery, data_t'($urandom()), BitSelW'($urandom()));
    issue_ack(1'b0);
  endtask

  initial begin : stimulus
    logic [AddrW-1:0]   base_v;
    logic [LenW-1:0]    len_v;
    logic [PassW-1:0]   pass_v;
    logic [ErrLimW-1:0] err_v;
    int                 r;

    tracker = new();
    calm = 1'b0;
    useful_beats = 0;
    corrupted_reads = 0;
    settings_used = 0;
    stall_left = 0;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.command = CmdQuery;
    in_if.read_data = '0;
    in_if.bit_select = '0;
    out_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // before any start: a query and a stray completion
    send_beat(CmdQuery, 32'hffff_ffff, 5'd31);
    send_beat(CmdAck, 32'h0000_0000, 5'd0);
    // start on the register defaults
    start_test();
    issue_ack(1'b0);
    issue_ack(1'b0);
    // nothing to do: zero length, zero passes, zero error limit
    apply_setting(32'h0, '0, PassW'(8), ErrLimW'(1), 1'b0);
    start_test();
    apply_setting(32'h0, LenW'(4), '0, ErrLimW'(1), 1'b0);
    start_test();
    apply_setting(32'h0, LenW'(4), PassW'(1), '0, 1'b0);
    start_test();
    // region wrapping at the top of the address space, address xor on
    apply_setting(32'hffff_fff8, LenW'(3), PassW'(1), '1, 1'b1);
    start_test();
    repeat (3) issue_ack(1'b0);
    send_beat(CmdAck, tracker.word_now() ^ 32'hffff_ffff, 5'd7);
    issue_ack(1'b0);
    send_beat(CmdAck, tracker.word_now() ^ 32'h8000_0000, 5'd31);
    send_beat(CmdQuery, 32'h0, 5'd0);
    send_beat(CmdQuery, 32'hffff_ffff, 5'd31);
    send_beat(CmdAck, 32'h5555_5555, 5'd1);
    send_beat(CmdSpare, 32'haaaa_aaaa, 5'd30);
    // oversized length, unaligned base, widest counts
    apply_setting(32'h0000_0003, '1, '1, '1, 1'b0);
    start_test();
    issue_ack(1'b0);
    issue_ack(1'b0);

    // random settings, each followed by one test run
    while (useful_beats < ItemTarget) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 4))
        0:       base_v = '0;
        1:       base_v = 32'hffff_fffc;
        2:       base_v = {30'($urandom_range(0, 32'h3fff_ffff)), 2'b00};
        3:       base_v = $urandom();
        default: base_v = 32'hffff_fff0;
      endcase
      len_v = LenW'($urandom_range(1, 6));
      pass_v = PassW'($urandom_range(1, 3));
      r = $urandom_range(0, 99);
      if (r < 12) begin
        len_v = LenW'($urandom_range(1, 2));
        pass_v = PassW'($urandom_range(8, 10));
      end else if (r < 18) begin
        len_v = LenW'($urandom_range(7, 16));
      end else if (r < 21) begin
        len_v = '0;
      end else if (r < 24) begin
        len_v = r[0] ? '1 : LenW'(32'h4000_0000 + $urandom_range(0, 255));
      end else if (r < 27) begin
        pass_v = '0;
      end else if (r < 30) begin
        pass_v = '1;
      end
      case ($urandom_range(0, 5))
        0:       err_v = '0;
        1:       err_v = ErrLimW'(1);
        2, 3:    err_v = ErrLimW'($urandom_range(2, 6));
        4:       err_v = '1;
        default: err_v = ErrLimW'($urandom());
      endcase
      apply_setting(base_v, len_v, pass_v, err_v, 1'($urandom()));
      run_session();
    end

    calm = 1'b0;
    drain();
    repeat (4) @(posedge clk_i);
    $display("covered %0d command beats under %0d register settings, %0d reads corrupted",
             useful_beats, settings_used, corrupted_reads);
    $display("checked %0d result beats, %0d field mismatches",
             tracker.checked_beats, tracker.bad_fields);
    if (tracker.bad_fields == 0 && tracker.awaited_beats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
